>>> hw/rtl/idt_pkg.sv
// Shared types and codes for the indentation tracker.
`default_nettype none

package idt_pkg;

   localparam int LEVEL_FIELD_BITS = 10;
   localparam int LINE_BITS        = 24;

   localparam logic OP_LINE = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [1:0] {
      KIND_INDENT = 2'd0,
      KIND_DEDENT = 2'd1,
      KIND_EOF    = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic                        op;
      logic [LEVEL_FIELD_BITS-1:0] indent_level;
      logic [LINE_BITS-1:0]        line_number;
   } req_word_type;

   typedef struct packed {
      kind_type             kind;
      logic [LINE_BITS-1:0] token_line;
      logic                 last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FETCH,
      ST_ERROR
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic     load_item;
      logic     push;
      logic     pop;
      logic     fetch_top;
      logic     zero_top;
      logic     emit;
      kind_type emit_kind;
      logic     emit_last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op;
      logic gt;
      logic eq;
      logic lt;
      logic full;
      logic multi;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/idt_ctrl.sv
// Sequencing state machine for the indentation tracker.
`default_nettype none

module idt_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  idt_pkg::dp_status_type status,
   output idt_pkg::dp_cmd_type    cmd
);
   import idt_pkg::*;

   state_type state_ff, state_in;
   logic      halted_ff, halted_in;
   logic      pend_ff, pend_in;   // a DEDENT is owed, its last flag not yet known

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         halted_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         halted_ff <= halted_in;
         pend_ff   <= pend_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      halted_in = halted_ff;
      pend_in   = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            pend_in = 1'b0;
            if (req_valid && !halted_ff) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.op == OP_END) begin
               if (!status.multi && status.rsp_free) state_in = ST_IDLE;
            end else if (pend_ff) begin
               if (status.rsp_free) begin
                  if (status.lt)      state_in = ST_FETCH;
                  else if (status.eq) state_in = ST_IDLE;
                  else                state_in = ST_ERROR;
               end
            end else if (status.gt) begin
               if (status.rsp_free) begin
                  state_in = ST_IDLE;
                  if (status.full) halted_in = 1'b1;
               end
            end else if (status.eq) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
               pend_in  = 1'b1;
            end
         end
         ST_FETCH: state_in = ST_EVAL;
         ST_ERROR: begin
            if (status.rsp_free) begin
               state_in  = ST_IDLE;
               halted_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: cmd.load_item = req_valid && !halted_ff;
         ST_EVAL: begin
            if (status.op == OP_END) begin
               if (status.rsp_free) begin
                  cmd.emit = 1'b1;
                  if (status.multi) begin
                     cmd.pop       = 1'b1;
                     cmd.emit_kind = KIND_DEDENT;
                  end else begin
                     cmd.zero_top  = 1'b1;
                     cmd.emit_kind = KIND_EOF;
                     cmd.emit_last = 1'b1;
                  end
               end
            end else if (pend_ff) begin
               if (status.rsp_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_DEDENT;
                  cmd.emit_last = status.eq;
                  cmd.pop       = status.lt;
               end
            end else if (status.gt) begin
               if (status.rsp_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  cmd.emit_kind = status.full ? KIND_ERROR : KIND_INDENT;
                  cmd.push      = !status.full;
               end
            end else if (status.lt) begin
               cmd.pop = 1'b1;
            end
         end
         ST_FETCH: cmd.fetch_top = 1'b1;
         ST_ERROR: begin
            cmd.emit      = status.rsp_free;
            cmd.emit_kind = KIND_ERROR;
            cmd.emit_last = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/idt_dp.sv
// Level stack, compare and result register of the indentation tracker.
`default_nettype none

module idt_dp #(
   parameter int STACK_DEPTH = 32,
   parameter int LEVEL_BITS  = 10
) (
   input  wire                    clock,
   input  wire                    reset,
   input  idt_pkg::req_word_type  req_word,
   output idt_pkg::rsp_word_type  rsp_word,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   input  idt_pkg::dp_cmd_type    cmd,
   output idt_pkg::dp_status_type status
);
   import idt_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [LEVEL_BITS-1:0] req_level;
   logic                  op_ff;
   logic [LEVEL_BITS-1:0] level_ff;
   logic [LINE_BITS-1:0]  line_ff;
   logic [LEVEL_BITS-1:0] top_ff, top_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [LEVEL_BITS-1:0] level_stack_ff [STACK_DEPTH];
   logic [LEVEL_BITS-1:0] rd_level_ff;
   logic [CW-1:0]         below_idx;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff;

   if (LEVEL_BITS <= LEVEL_FIELD_BITS) begin : g_trunc
      assign req_level = req_word.indent_level[LEVEL_BITS-1:0];
   end else begin : g_ext
      assign req_level = {{(LEVEL_BITS - LEVEL_FIELD_BITS){1'b0}}, req_word.indent_level};
   end

   assign below_idx = count_ff - CW'(2);

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff    <= req_word.op;
         level_ff <= req_level;
         line_ff  <= req_word.line_number;
      end
   end

   // stack memory: entry 0 is never read, the bottom level is implied
   always_ff @(posedge clock) begin
      if (cmd.push) level_stack_ff[count_ff[AW-1:0]] <= level_ff;
      rd_level_ff <= level_stack_ff[below_idx[AW-1:0]];
   end

   always_comb begin
      top_in   = top_ff;
      count_in = count_ff;
      if (cmd.push) begin
         top_in   = level_ff;
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.fetch_top) top_in = (count_ff == CW'(1)) ? '0 : rd_level_ff;
      if (cmd.zero_top)  top_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         count_ff <= CW'(1);
      end else begin
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   // output register
   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_word_ff.kind       <= cmd.emit_kind;
         rsp_word_ff.token_line <= line_ff;
         rsp_word_ff.last       <= cmd.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      status.op       = op_ff;
      status.gt       = level_ff > top_ff;
      status.eq       = level_ff == top_ff;
      status.lt       = level_ff < top_ff;
      status.full     = count_ff == CW'(STACK_DEPTH);
      status.multi    = count_ff > CW'(1);
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire

>>> hw/rtl/indent_dedent_tracker_top.sv
// Top level of the indentation tracker: controller plus datapath.
`default_nettype none

// Indentation tracker, offside rule. One req word per non-blank source line
// (op = line, with its indent count and line number) or one end-of-input word.
// A deeper line pushes its level and gives INDENT; a shallower one pops and
// gives one DEDENT per level; a line that lands between levels, or a push
// onto a full stack, gives an indentation error and the block then swallows
// every req word without answer until reset. End of input pops to the bottom
// level with DEDENTs and finishes with EOF. Every rsp word carries the line
// number of the req word that caused it; last marks the final one.
// Timing: a word is taken in one cycle and judged in the next. Each DEDENT of
// a line passes through the FETCH state, as the new top level is read back
// from the stack memory through its registered read port; DEDENTs at end of
// input need no such read-back.
// The rsp side has a one-word output register; when it is held by rsp_stall
// the block waits before placing the next word. No clearing pass is needed
// after reset: the bottom level is implied and upper entries are written
// before they are read.

module indent_dedent_tracker_top #(
   parameter int STACK_DEPTH = 32,
   parameter int LEVEL_BITS  = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  idt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output idt_pkg::rsp_word_type rsp_word
);
   import idt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   idt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   idt_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .LEVEL_BITS  (LEVEL_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the indentation tracker (offside rule stack).
`timescale 1ns / 1ps

module tb_top;
   import idt_pkg::*;

   localparam int STACK_DEPTH    = 32;
   localparam int LEVEL_BITS     = 10;
   localparam int LEVEL_MAX      = (1 << LEVEL_BITS) - 1;
   localparam int RANDOM_WORDS   = 350;
   localparam int HOLD_CYCLES    = 400;   // long rsp hold-off, fills the block
   localparam int SETTLE_CYCLES  = 8;     // quiet time after the last rsp word
   localparam int TAIL_CYCLES    = 80;    // margin before the summary is printed
   localparam int WATCHDOG_LIMIT = 4000;  // idle cycles before giving up
   localparam int REPORT_LINES   = 40;

   typedef enum int {
      RX_FREE,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   indent_dedent_tracker_top #(
      .STACK_DEPTH (STACK_DEPTH),
      .LEVEL_BITS  (LEVEL_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the tracker: open levels, their count and the lock-up flag.
   // ---------------------------------------------------------------------
   logic [LEVEL_BITS-1:0] open_levels [STACK_DEPTH];
   int                    open_count;
   logic                  locked_up;
   rsp_word_type          token_q [$];   // tokens still owed by the block

   int          mismatches    = 0;
   int          words_taken   = 0;
   int          words_ignored = 0;
   int          deepest       = 1;
   int          kind_counts [4];
   int          burst_left    = 0;
   int unsigned line_cursor;
   int          hold_ask      = 0;
   string       lockup_case   = "none";

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= REPORT_LINES)
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic void queue_token(input kind_type k, input logic [LINE_BITS-1:0] line,
                                       input logic is_last);
      rsp_word_type t;
      t.kind       = k;
      t.token_line = line;
      t.last       = is_last;
      token_q.push_back(t);
   endfunction

   // Works out the tokens one accepted req word owes and updates the shadow.
   task automatic track_line(input req_word_type w);
      logic [LEVEL_BITS-1:0] lvl;
      int                    pops;
      logic                  matched;
      lvl = w.indent_level;
      words_taken++;
      if (locked_up) begin
         words_ignored++;   // swallowed without answer until reset
      end else if (w.op == OP_END) begin
         // unwind to the bottom level; the level field plays no part
         while (open_count > 1) begin
            open_count--;
            queue_token(KIND_DEDENT, w.line_number, 1'b0);
         end
         queue_token(KIND_EOF, w.line_number, 1'b1);
      end else if (lvl > open_levels[open_count-1]) begin
         if (open_count >= STACK_DEPTH) begin
            // deeper line with no room left: flagged, nothing pushed
            locked_up = 1'b1;
            queue_token(KIND_ERROR, w.line_number, 1'b1);
         end else begin
            open_levels[open_count] = lvl;
            open_count++;
            if (open_count > deepest) deepest = open_count;
            queue_token(KIND_INDENT, w.line_number, 1'b1);
         end
      end else begin
         pops = 0;
         while (open_count - pops > 1 && lvl < open_levels[open_count-pops-1]) pops++;
         matched = (lvl == open_levels[open_count-pops-1]);
         // last goes on the final DEDENT only when no error follows
         for (int i = 0; i < pops; i++)
            queue_token(KIND_DEDENT, w.line_number, matched && (i == pops - 1));
         open_count -= pops;
         if (!matched) begin
            locked_up = 1'b1;
            queue_token(KIND_ERROR, w.line_number, 1'b1);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender: bursts of random length, random gaps between them. Valid stays
   // high from one word to the next within a burst.
   // ---------------------------------------------------------------------
   task automatic send_word(input req_word_type w);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      track_line(w);
   endtask

   task automatic send_fields(input logic op, input int unsigned lvl, input int unsigned line);
      req_word_type w;
      w.op           = op;
      w.indent_level = LEVEL_FIELD_BITS'(lvl);
      w.line_number  = LINE_BITS'(line);
      send_word(w);
   endtask

   // Sender pauses until every owed token has come back.
   task automatic wait_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned next_line();
      if ($urandom_range(0, 7) == 0) line_cursor = $urandom();
      else                           line_cursor += $urandom_range(1, 4);
      return line_cursor & 32'hFF_FFFF;
   endfunction

   // Well-formed line for the current nesting: indent, same level, dedent to a
   // level still open, or the odd end of input mid-stream.
   task automatic pick_line(output req_word_type w);
      int unsigned roll;
      int unsigned top;
      int unsigned span;
      top  = open_levels[open_count-1];
      roll = $urandom_range(0, 99);
      w.op          = OP_LINE;
      w.line_number = LINE_BITS'(next_line());
      if (roll < 4) begin
         w.op           = OP_END;
         w.indent_level = LEVEL_FIELD_BITS'($urandom());
      end else if (roll < 48 && open_count < STACK_DEPTH && top < LEVEL_MAX) begin
         span = LEVEL_MAX - top;
         if ($urandom_range(0, 9) == 0)
            w.indent_level = LEVEL_FIELD_BITS'(top + $urandom_range(1, span));
         else
            w.indent_level = LEVEL_FIELD_BITS'(top + $urandom_range(1, (span < 8) ? span : 8));
      end else if (roll < 72 && open_count > 1) begin
         w.indent_level = open_levels[$urandom_range(0, open_count - 2)];
      end else begin
         w.indent_level = LEVEL_FIELD_BITS'(top);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, single and multiple dedents, EOF with and without open
   // levels, and a fresh stream after EOF.
   task automatic test_directed();
      send_fields(OP_LINE, 0, 0);                 // same as bottom: silent
      send_fields(OP_LINE, 1, 1);                 // INDENT
      send_fields(OP_LINE, LEVEL_MAX, 24'hFFFFFF); // deepest level, top line number
      send_fields(OP_LINE, LEVEL_MAX, 2);         // same level
      send_fields(OP_LINE, 1, 3);                 // one DEDENT
      send_fields(OP_LINE, 0, 4);
      send_fields(OP_LINE, 2, 5);
      send_fields(OP_LINE, 3, 6);
      send_fields(OP_LINE, 4, 7);
      send_fields(OP_LINE, 0, 8);                 // three DEDENTs from one line
      send_fields(OP_END, 0, 9);                  // EOF alone
      send_fields(OP_LINE, 5, 10);
      send_fields(OP_LINE, 9, 11);
      send_fields(OP_END, LEVEL_MAX, 24'hAAAAAA); // level field ignored on end
      send_fields(OP_LINE, 0, 24'h555555);        // new stream after EOF
      send_fields(OP_LINE, 512, 13);
      send_fields(OP_LINE, 512, 14);
      send_fields(OP_LINE, 0, 15);
      send_fields(OP_END, 0, 16);
      send_fields(OP_END, 0, 17);                 // back-to-back EOF
      wait_drained();
   endtask

   // Nest to a full stack while the receiver holds off, so the block backs
   // up and stalls its req side; then unwind with the longest EOF burst.
   task automatic test_full_stack();
      hold_ask++;
      for (int i = 1; i < STACK_DEPTH; i++) send_fields(OP_LINE, i * 33, next_line());
      send_fields(OP_LINE, LEVEL_MAX, next_line());   // same level on a full stack
      send_fields(OP_END, $urandom(), next_line());   // 31 DEDENTs then EOF
      wait_drained();
   endtask

   task automatic test_random_stream();
      req_word_type w;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 3) hold_ask++;
         if (n == 2 * RANDOM_WORDS / 3) wait_drained();
         pick_line(w);
         send_word(w);
      end
      wait_drained();
   endtask

   // Only one lock-up fits in a run, as reset comes once: the seed picks which.
   // Words after it must be swallowed silently.
   task automatic test_lockup();
      int unsigned a;
      req_word_type w;
      send_fields(OP_END, 0, next_line());
      if ($urandom_range(0, 1) == 0) begin
         lockup_case = "a push onto a full stack";
         for (int i = 1; i < STACK_DEPTH; i++) send_fields(OP_LINE, i * 32, next_line());
         send_fields(OP_LINE, 993 + $urandom_range(0, 30), next_line());
      end else begin
         lockup_case = "a dedent between open levels";
         a = $urandom_range(2, 300);
         send_fields(OP_LINE, a, next_line());
         send_fields(OP_LINE, a + $urandom_range(2, 300), next_line());
         send_fields(OP_LINE, a + 400 + $urandom_range(0, 300), next_line());
         send_fields(OP_LINE, a + $urandom_range(1, 1), next_line());  // lands between
      end
      for (int i = 0; i < 8; i++) begin
         w = req_word_type'($bits(req_word_type)'({$urandom(), $urandom()}));
         send_word(w);
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Receiver: stall pattern changes mode at random intervals; a long
   // hold-off is asked for by bumping hold_ask.
   // ---------------------------------------------------------------------
   rx_mode_type stall_mode = RX_FREE;
   int          mode_left  = 0;
   int          hold_left  = 0;
   int          hold_seen  = 0;
   int          rx_phase   = 0;

   always @(posedge clock) begin
      rx_phase++;
      if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(8, 64);
         end
         mode_left--;
         case (stall_mode)
            RX_FREE: begin
               rsp_stall <= 1'b0;
            end
            RX_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            RX_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ((rx_phase % 5) < 2);
            end
         endcase
      end
   end

   // Checker: every rsp word taken is matched against the oldest owed token.
   rsp_word_type want_token;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         kind_counts[rsp_word.kind]++;
         if (token_q.size() == 0) begin
            report_mismatch("rsp word with nothing owed", 32'(rsp_word), 0);
         end else begin
            want_token = token_q.pop_front();
            if (rsp_word.kind !== want_token.kind)
               report_mismatch("kind", 32'(rsp_word.kind), 32'(want_token.kind));
            if (rsp_word.token_line !== want_token.token_line)
               report_mismatch("token_line", 32'(rsp_word.token_line),
                               32'(want_token.token_line));
            if (rsp_word.last !== want_token.last)
               report_mismatch("last", 32'(rsp_word.last), 32'(want_token.last));
         end
      end
   end

   // Watchdog: too long without a word moving on either side ends the run.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d tokens owed",
                  idle_cycles, token_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      foreach (open_levels[i]) open_levels[i] = '0;
      foreach (kind_counts[i]) kind_counts[i] = 0;
      open_count  = 1;
      locked_up   = 1'b0;
      line_cursor = $urandom_range(0, 1000);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_stack();
      test_random_stream();
      test_lockup();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d req words: %0d INDENT, %0d DEDENT, %0d EOF, %0d error tokens,",
               words_taken, kind_counts[KIND_INDENT], kind_counts[KIND_DEDENT],
               kind_counts[KIND_EOF], kind_counts[KIND_ERROR]);
      $display("nesting to %0d; locked up on %s, then %0d req words swallowed; %0d mismatches",
               deepest, lockup_case, words_ignored, mismatches);
      if (mismatches == 0 && token_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
